@@ rtl/llti_pkg.sv @@
// shared types, codes and constant tables of the log-log table interpolator
package llti_pkg;

	localparam int LOG_FRAC = 24;
	localparam int LG_W     = LOG_FRAC + 5;

	typedef logic [31:0]     q16_t;
	typedef logic [LG_W-1:0] lg_t;

	localparam logic [1:0] FN_CLEAR  = 2'd0;
	localparam logic [1:0] FN_APPEND = 2'd1;
	localparam logic [1:0] FN_QUERY  = 2'd2;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_FULL   = 3'd1;
	localparam logic [2:0] ST_REJECT = 3'd2;
	localparam logic [2:0] ST_BELOW  = 3'd3;
	localparam logic [2:0] ST_CLAMP  = 3'd4;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// successive square roots of 2 in Q1.31, entry i is the 2^-(i+1) power
	function automatic logic [LOG_FRAC*32-1:0] ex_root_table();
		logic [LOG_FRAC*32-1:0] tab;
		logic [63:0] r;
		logic [63:0] v;
		logic [63:0] s;
		logic [63:0] b;
		tab = '0;
		r = 64'd1 << 32;
		for (int i = 0; i < LOG_FRAC; i++) begin
			v = r << 31;
			s = '0;
			b = 64'd1 << 62;
			for (int k = 0; k < 32; k++) begin
				if (v >= s + b) begin
					v = v - (s + b);
					s = (s >> 1) + b;
				end else begin
					s = s >> 1;
				end
				b = b >> 2;
			end
			r = s;
			tab[i*32 +: 32] = r[31:0];
		end
		return tab;
	endfunction

	localparam logic [LOG_FRAC*32-1:0] EX_ROOTS = ex_root_table();

endpackage

@@ rtl/llti_if.sv @@
// item and result channel interfaces of the log-log table interpolator
interface llti_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [2:0]  channel;
	logic [31:0] energy;
	logic [31:0] point_value;
	modport source(output valid, func, channel, energy, point_value, input ready);
	modport sink(input valid, func, channel, energy, point_value, output ready);
endinterface

interface llti_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] interp_value;
	logic [2:0]  status;
	modport source(output valid, interp_value, status, input ready);
	modport sink(input valid, interp_value, status, output ready);
endinterface

@@ rtl/llti_mul.sv @@
// shared 32x32 multiplier with registered product
module llti_mul
	import llti_pkg::*;
(
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);

	logic [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

	assign p = p_q;

endmodule

@@ rtl/llti_div.sv @@
// restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle
module llti_div
	import llti_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output div_stat_t   stat,
	output logic [63:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] dvd_q;
	logic [31:0] rem_q;
	logic [31:0] dsr_q;
	logic [32:0] rem_sh;
	logic [32:0] rem_sub;
	logic        fits;

	always_comb begin
		rem_sh  = {rem_q, dvd_q[63]};
		fits    = rem_sh >= {1'b0, dsr_q};
		rem_sub = rem_sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend register fills with quotient bits from the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[31:0] : rem_sh[31:0];
			dvd_q <= {dvd_q[62:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;

endmodule

@@ rtl/loglog_table_interpolator.sv @@
// log-log table interpolator: per-channel point tables with a shared multiply/divide sequencer
//
// Items arrive on the item channel (valid/ready) and each gives exactly one result on the
// result channel. func clear empties a channel table, append adds one point (energy, value)
// when the energy is nonzero and above the last stored one, query returns the interpolated
// value of the table at the given energy.
// Items are handled one at a time; ready is high only while the sequencer is idle.
// Steps per item: clear needs only the dispatch, append reads the last stored point, checks
// it and writes (no read on an empty table), a query outside the table ends after the ends.
// A query inside the table runs a binary search of up to log2(MAX_POINTS) steps, then a
// last compare and a read of the bracketing pair. Linear interpolation then multiplies and
// waits on the divider. Log-log interpolation runs five log2 evaluations on the shared
// multiplier, a divide and an exp2 evaluation. The result is loaded into the output
// register as the sequencer leaves its last step.
// The result is held in an output register; while a stalled receiver keeps it there, the
// sequencer waits at its last step until the register frees, and item ready stays low.
// Reset empties every channel table and drops any pending result; the point memories
// need no clearing since entries beyond a table's count are never read.
module loglog_table_interpolator
	import llti_pkg::*;
#(
	parameter int NUM_CHANNELS = 7,
	parameter int MAX_POINTS   = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	llti_item_if.sink            item,
	llti_result_if.source        result
);

	localparam int IDXW  = $clog2(MAX_POINTS);
	localparam int CNTW  = $clog2(MAX_POINTS + 1);
	localparam int CHW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int DEPTH = NUM_CHANNELS << IDXW;

	typedef enum logic [29:0] {
		S_IDLE     = 30'(1),
		S_DISPATCH = 30'(1) << 1,
		S_APP_RD   = 30'(1) << 2,
		S_APP_CHK  = 30'(1) << 3,
		S_APP_WR   = 30'(1) << 4,
		S_Q_RD0    = 30'(1) << 5,
		S_Q_RD1    = 30'(1) << 6,
		S_Q_CHKL   = 30'(1) << 7,
		S_BS       = 30'(1) << 8,
		S_BS_CMP   = 30'(1) << 9,
		S_PAIR0    = 30'(1) << 10,
		S_PAIR1    = 30'(1) << 11,
		S_PAIR2    = 30'(1) << 12,
		S_SEL      = 30'(1) << 13,
		S_LIN_MUL  = 30'(1) << 14,
		S_LIN_DIV  = 30'(1) << 15,
		S_LIN_WAIT = 30'(1) << 16,
		S_LG_LOAD  = 30'(1) << 17,
		S_LG_NORM  = 30'(1) << 18,
		S_LG_SQ    = 30'(1) << 19,
		S_LG_SQW   = 30'(1) << 20,
		S_LG_STORE = 30'(1) << 21,
		S_LL_DIFF  = 30'(1) << 22,
		S_LL_MUL   = 30'(1) << 23,
		S_LL_DIV   = 30'(1) << 24,
		S_LL_WAIT  = 30'(1) << 25,
		S_EX_STEP  = 30'(1) << 26,
		S_EX_MULW  = 30'(1) << 27,
		S_EX_FIN   = 30'(1) << 28,
		S_DONE     = 30'(1) << 29
	} state_t;

	state_t          state_q;
	logic [CNTW-1:0] cnt_q [NUM_CHANNELS];

	logic [1:0]      func_q;
	logic [CHW-1:0]  ch_q;
	logic            ch_ok_q;
	q16_t            e_q;
	q16_t            pv_q;
	logic [CNTW-1:0] cur_cnt_q;
	logic [CNTW-1:0] lo_q;
	logic [CNTW-1:0] hi_q;
	q16_t            e0_q, e1_q, v0_q, v1_q;
	q16_t            value_q;
	logic [2:0]      status_q;
	q16_t            out_value_q;
	logic [2:0]      out_status_q;
	logic            out_valid_q;

	logic [2:0]      lg_sel_q;
	logic [31:0]     lg_m_q;
	logic [4:0]      lg_top_q;
	logic [LOG_FRAC-1:0] lg_frac_q;
	lg_t             lg_q [5];
	logic [4:0]      step_q;
	logic [31:0]     acc_q;
	logic [LOG_FRAC-1:0] ex_f_q;
	logic [4:0]      ex_n_q;

	q16_t            en_mem [DEPTH];
	q16_t            val_mem [DEPTH];
	q16_t            en_rd, val_rd;
	logic [IDXW-1:0] mem_idx;
	logic            mem_we;

	logic [31:0]     mul_a, mul_b;
	logic [63:0]     mul_p;
	logic            div_start;
	logic [31:0]     div_dsr;
	div_stat_t       div_stat;
	logic [63:0]     div_quo;

	logic            in_ch_ok;
	logic [CNTW:0]   mid_sum;
	logic [IDXW-1:0] mid;
	logic [CNTW-1:0] cnt_m1;
	logic [4:0]      norm_sh;
	lg_t             dd, de, dv, lg_res;
	logic            lv_up, v_up;
	q16_t            lg_opnd;
	lg_t             y_ll;

	always_comb begin
		in_ch_ok = {2'b00, item.channel} < 5'(NUM_CHANNELS);
		mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
		mid      = mid_sum[IDXW:1];
		cnt_m1   = cur_cnt_q - CNTW'(1);
		norm_sh  = 5'd16 >> step_q;
		dd       = lg_q[2] - lg_q[0];
		de       = lg_q[1] - lg_q[0];
		lv_up    = lg_q[4] >= lg_q[3];
		dv       = lv_up ? (lg_q[4] - lg_q[3]) : (lg_q[3] - lg_q[4]);
		v_up     = v1_q >= v0_q;
		lg_res   = {lg_top_q, lg_frac_q};
		y_ll     = lv_up ? (lg_q[3] + div_quo[LG_W-1:0]) : (lg_q[3] - div_quo[LG_W-1:0]);
		case (lg_sel_q)
			3'd0:    lg_opnd = e0_q;
			3'd1:    lg_opnd = e_q;
			3'd2:    lg_opnd = e1_q;
			3'd3:    lg_opnd = v0_q;
			default: lg_opnd = v1_q;
		endcase
	end

	// point memories share one address, read data registered
	always_comb begin
		mem_we  = 1'b0;
		mem_idx = '0;
		unique case (state_q)
			S_APP_RD: mem_idx = cnt_m1[IDXW-1:0];
			S_APP_WR: begin
				mem_idx = cur_cnt_q[IDXW-1:0];
				mem_we  = 1'b1;
			end
			S_Q_RD1:  mem_idx = cnt_m1[IDXW-1:0];
			S_BS:     mem_idx = mid;
			S_PAIR0:  mem_idx = lo_q[IDXW-1:0] - IDXW'(1);
			S_PAIR1:  mem_idx = lo_q[IDXW-1:0];
			default:  mem_idx = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			en_mem[{ch_q, mem_idx}]  <= e_q;
			val_mem[{ch_q, mem_idx}] <= pv_q;
		end
		en_rd  <= en_mem[{ch_q, mem_idx}];
		val_rd <= val_mem[{ch_q, mem_idx}];
	end

	// operand selection for the shared arithmetic units
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_dsr   = '0;
		unique case (state_q)
			S_LIN_MUL: begin
				mul_a = e_q - e0_q;
				mul_b = v_up ? (v1_q - v0_q) : (v0_q - v1_q);
			end
			S_LIN_DIV: begin
				div_start = 1'b1;
				div_dsr   = e1_q - e0_q;
			end
			S_LG_SQ: begin
				mul_a = lg_m_q;
				mul_b = lg_m_q;
			end
			S_LL_MUL: begin
				mul_a = 32'(de);
				mul_b = 32'(dv);
			end
			S_LL_DIV: begin
				div_start = 1'b1;
				div_dsr   = 32'(dd);
			end
			S_EX_STEP: begin
				mul_a = acc_q;
				mul_b = EX_ROOTS[{step_q, 5'd0} +: 32];
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	llti_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	llti_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_p),
		.divisor  (div_dsr),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (state_q == S_DONE && (!out_valid_q || result.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					unique case (func_q)
						FN_CLEAR: begin
							if (ch_ok_q) begin
								cnt_q[ch_q] <= '0;
							end
							state_q <= S_DONE;
						end
						FN_APPEND: begin
							if (!ch_ok_q || e_q == '0 || cur_cnt_q >= CNTW'(MAX_POINTS)) begin
								state_q <= S_DONE;
							end else if (cur_cnt_q == '0) begin
								state_q <= S_APP_WR;
							end else begin
								state_q <= S_APP_RD;
							end
						end
						FN_QUERY: begin
							state_q <= (!ch_ok_q || cur_cnt_q == '0) ? S_DONE : S_Q_RD0;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_APP_RD:  state_q <= S_APP_CHK;
				S_APP_CHK: state_q <= (e_q <= en_rd) ? S_DONE : S_APP_WR;
				S_APP_WR: begin
					cnt_q[ch_q] <= cur_cnt_q + CNTW'(1);
					state_q     <= S_DONE;
				end
				S_Q_RD0:  state_q <= S_Q_RD1;
				S_Q_RD1:  state_q <= (e_q <= en_rd) ? S_DONE : S_Q_CHKL;
				S_Q_CHKL: state_q <= (e_q >= en_rd) ? S_DONE : S_BS;
				S_BS:     state_q <= (lo_q < hi_q) ? S_BS_CMP : S_PAIR0;
				S_BS_CMP: state_q <= S_BS;
				S_PAIR0:  state_q <= S_PAIR1;
				S_PAIR1:  state_q <= S_PAIR2;
				S_PAIR2:  state_q <= S_SEL;
				S_SEL: begin
					if (e_q == e1_q) begin
						state_q <= S_DONE;
					end else if (v0_q == '0 || v1_q == '0) begin
						state_q <= S_LIN_MUL;
					end else begin
						state_q <= S_LG_LOAD;
					end
				end
				S_LIN_MUL:  state_q <= S_LIN_DIV;
				S_LIN_DIV:  state_q <= S_LIN_WAIT;
				S_LIN_WAIT: begin
					if (div_stat.done) begin
						state_q <= S_DONE;
					end
				end
				S_LG_LOAD: state_q <= S_LG_NORM;
				S_LG_NORM: begin
					if (step_q == 5'd4) begin
						state_q <= S_LG_SQ;
					end
				end
				S_LG_SQ:  state_q <= S_LG_SQW;
				S_LG_SQW: state_q <= (step_q == 5'(LOG_FRAC - 1)) ? S_LG_STORE : S_LG_SQ;
				S_LG_STORE: state_q <= (lg_sel_q == 3'd4) ? S_LL_DIFF : S_LG_LOAD;
				S_LL_DIFF: state_q <= (dd == '0) ? S_LIN_MUL : S_LL_MUL;
				S_LL_MUL:  state_q <= S_LL_DIV;
				S_LL_DIV:  state_q <= S_LL_WAIT;
				S_LL_WAIT: begin
					if (div_stat.done) begin
						state_q <= S_EX_STEP;
					end
				end
				S_EX_STEP: begin
					if (ex_f_q[LOG_FRAC-1]) begin
						state_q <= S_EX_MULW;
					end else if (step_q == 5'(LOG_FRAC - 1)) begin
						state_q <= S_EX_FIN;
					end
				end
				S_EX_MULW: state_q <= (step_q == 5'(LOG_FRAC - 1)) ? S_EX_FIN : S_EX_STEP;
				S_EX_FIN:  state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (item.valid) begin
					func_q    <= item.func;
					ch_q      <= CHW'(item.channel);
					ch_ok_q   <= in_ch_ok;
					e_q       <= item.energy;
					pv_q      <= item.point_value;
					cur_cnt_q <= in_ch_ok ? cnt_q[CHW'(item.channel)] : '0;
				end
			end
			S_DISPATCH: begin
				value_q <= '0;
				unique case (func_q)
					FN_CLEAR: status_q <= ST_OK;
					FN_APPEND: begin
						if (!ch_ok_q) begin
							status_q <= ST_REJECT;
						end else if (cur_cnt_q >= CNTW'(MAX_POINTS)) begin
							status_q <= ST_FULL;
						end else if (e_q == '0) begin
							status_q <= ST_REJECT;
						end else begin
							status_q <= ST_OK;
						end
					end
					FN_QUERY: begin
						if (!ch_ok_q || cur_cnt_q == '0) begin
							status_q <= ST_BELOW;
						end else begin
							status_q <= ST_OK;
						end
					end
					default: status_q <= ST_REJECT;
				endcase
			end
			S_APP_CHK: begin
				if (e_q <= en_rd) begin
					status_q <= ST_REJECT;
				end
			end
			S_Q_RD1: begin
				if (e_q <= en_rd) begin
					status_q <= ST_BELOW;
				end
			end
			S_Q_CHKL: begin
				if (e_q >= en_rd) begin
					value_q  <= val_rd;
					status_q <= ST_CLAMP;
				end
				lo_q <= CNTW'(1);
				hi_q <= cnt_m1;
			end
			S_BS_CMP: begin
				if (en_rd >= e_q) begin
					hi_q <= CNTW'(mid);
				end else begin
					lo_q <= CNTW'(mid) + CNTW'(1);
				end
			end
			S_PAIR1: begin
				e0_q <= en_rd;
				v0_q <= val_rd;
			end
			S_PAIR2: begin
				e1_q <= en_rd;
				v1_q <= val_rd;
			end
			S_SEL: begin
				if (e_q == e1_q) begin
					value_q <= v1_q;
				end
				lg_sel_q <= '0;
			end
			S_LIN_WAIT: begin
				if (div_stat.done) begin
					value_q <= v_up ? (v0_q + div_quo[31:0]) : (v0_q - div_quo[31:0]);
				end
			end
			S_LG_LOAD: begin
				lg_m_q   <= lg_opnd;
				lg_top_q <= 5'd31;
				step_q   <= '0;
			end
			S_LG_NORM: begin
				// binary leading-one search: 16, 8, 4, 2, 1
				if ((lg_m_q >> (6'd32 - {1'b0, norm_sh})) == '0) begin
					lg_m_q   <= lg_m_q << norm_sh;
					lg_top_q <= lg_top_q - norm_sh;
				end
				step_q <= (step_q == 5'd4) ? 5'd0 : step_q + 5'd1;
			end
			S_LG_SQW: begin
				// square reached 2: emit a one and halve
				if (mul_p[63]) begin
					lg_m_q <= mul_p[63:32];
				end else begin
					lg_m_q <= mul_p[62:31];
				end
				lg_frac_q <= {lg_frac_q[LOG_FRAC-2:0], mul_p[63]};
				step_q    <= step_q + 5'd1;
			end
			S_LG_STORE: begin
				lg_q[lg_sel_q] <= lg_res;
				lg_sel_q       <= lg_sel_q + 3'd1;
			end
			S_LL_WAIT: begin
				if (div_stat.done) begin
					ex_f_q <= y_ll[LOG_FRAC-1:0];
					ex_n_q <= y_ll[LG_W-1:LOG_FRAC];
					acc_q  <= 32'd1 << 31;
					step_q <= '0;
				end
			end
			S_EX_STEP: begin
				if (!ex_f_q[LOG_FRAC-1]) begin
					ex_f_q <= ex_f_q << 1;
					step_q <= step_q + 5'd1;
				end
			end
			S_EX_MULW: begin
				acc_q  <= mul_p[62:31];
				ex_f_q <= ex_f_q << 1;
				step_q <= step_q + 5'd1;
			end
			S_EX_FIN: begin
				value_q <= acc_q >> (5'd31 - ex_n_q);
			end
			S_DONE: begin
				if (!out_valid_q || result.ready) begin
					out_value_q  <= value_q;
					out_status_q <= status_q;
				end
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

	assign item.ready          = (state_q == S_IDLE);
	assign result.valid        = out_valid_q;
	assign result.interp_value = out_value_q;
	assign result.status       = out_status_q;

`ifndef SYNTHESIS
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.status <= ST_CLAMP)
		else $error("result status out of range");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BS_CMP) |-> (lo_q < hi_q) && (hi_q < cur_cnt_q))
		else $error("binary search bounds broken");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APP_WR) |-> (cur_cnt_q < CNTW'(MAX_POINTS)) && ch_ok_q)
		else $error("append write into full table or bad channel");
`endif

endmodule
